/* src/dkcp_pkg.sv */
`timescale 1ns / 1ps

package dkcp_pkg;

	localparam int MAX_KEY   = 16;
	localparam int COL_W     = $clog2(MAX_KEY);
	localparam int WID_W     = $clog2(MAX_KEY + 1);
	localparam int BYTE_W    = 8;
	localparam int KEY_W     = 64;
	localparam int LEN_W     = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RANK,
		ST_PA,
		ST_PB,
		ST_PC,
		ST_FA,
		ST_FB,
		ST_FC,
		ST_DA,
		ST_DB
	} state_t;

	function automatic logic [WID_W-1:0] clamp_width(input logic [LEN_W-1:0] len);
		logic [WID_W-1:0] w;
		if (len == '0) begin
			w = WID_W'(1);
		end else if (int'(len) > MAX_KEY) begin
			w = WID_W'(MAX_KEY);
		end else begin
			w = WID_W'(len);
		end
		return w;
	endfunction

endpackage

/* src/double_key_column_permuter.sv */
`timescale 1ns / 1ps

// Double columnar transposition, one row at a time. Bytes are accepted one per
// beat while the block is idle; a row fills until key_length bytes have arrived
// or message_end is seen, and the row is then emitted as a burst with
// in_ready low. On the first byte of a message after any key write, one
// compare unit ranks the key, comparing every pair of characters, and the order
// is then folded into a permutation table. An encrypted row is emitted column
// by column in permuted order; decryption uses that pass to unscramble into a
// row buffer and then reads the bytes out in order, all bounded by row and table
// memories with one read port each. Output beats wait on out_ready through a
// one-deep output register. Key registers may be rewritten between bytes of a
// message; the running message keeps its latched width, order and mode.
module double_key_column_permuter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dkcp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dkcp_pkg::KEY_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 action,
	input  logic [dkcp_pkg::BYTE_W-1:0]          in_byte,
	input  logic                                 message_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dkcp_pkg::BYTE_W-1:0]          out_byte,
	output logic                                 out_last
);
	import dkcp_pkg::*;

	state_t state_q, state_d;

	logic [KEY_W-1:0]  key_low_q, key_high_q;
	logic [LEN_W-1:0]  key_len_q;
	logic              order_ready_q;
	logic              started_q;
	logic              mode_q;
	logic              end_q;
	logic              flush_pend_q;
	logic [WID_W-1:0]  width_q;
	logic [WID_W-1:0]  fill_q;
	logic [WID_W-1:0]  cnt_q;
	logic [COL_W-1:0]  i_q, j_q, k_q, rank_q;

	logic              out_valid_q, out_last_q;
	logic [BYTE_W-1:0] out_byte_q;

	logic [BYTE_W-1:0] row_mem   [MAX_KEY];
	logic [BYTE_W-1:0] plain_mem [MAX_KEY];
	logic [COL_W-1:0]  order_mem [MAX_KEY];
	logic [COL_W-1:0]  perm_mem  [MAX_KEY];

	logic [BYTE_W-1:0] row_rd_q, plain_rd_q;
	logic [COL_W-1:0]  order_rd_q, perm_rd_q;

	logic [2*KEY_W-1:0] key_all;
	logic [BYTE_W-1:0]  ci, cj;
	logic               rank_inc;
	logic [COL_W-1:0]   rank_fin;
	logic [WID_W-1:0]   clamp_w, eff_width, base_fill, new_fill;
	logic [COL_W-1:0]   wr_col, wm1, fill_m1;
	logic               accept, flush_now, s_hit, i_last, out_free;
	logic               out_load, plain_we, flush_done;
	logic [COL_W-1:0]   order_addr, row_addr;

	assign key_all   = {key_high_q, key_low_q};
	assign ci        = key_all[{i_q, 3'b000} +: BYTE_W];
	assign cj        = key_all[{j_q, 3'b000} +: BYTE_W];
	assign rank_inc  = (cj < ci) || ((cj == ci) && (j_q < i_q));
	assign rank_fin  = rank_q + COL_W'(rank_inc);

	assign clamp_w   = clamp_width(key_len_q);
	assign eff_width = started_q ? width_q : clamp_w;
	assign base_fill = started_q ? fill_q : '0;
	assign wr_col    = base_fill[COL_W-1:0];
	assign new_fill  = base_fill + WID_W'(1);
	assign accept    = in_valid && in_ready;
	assign flush_now = message_end || (new_fill >= eff_width);

	assign wm1      = COL_W'(width_q - WID_W'(1));
	assign fill_m1  = COL_W'(fill_q - WID_W'(1));
	assign s_hit    = {1'b0, perm_rd_q} < fill_q;
	assign i_last   = (i_q == wm1);
	assign out_free = !out_valid_q || out_ready;

	assign order_addr = (state_q == ST_PB) ? order_rd_q : i_q;
	assign row_addr   = mode_q ? k_q : perm_rd_q;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_load   = 1'b0;
		plain_we   = 1'b0;
		flush_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!started_q && !order_ready_q) begin
						state_d = ST_RANK;
					end else if (flush_now) begin
						state_d = ST_FA;
					end
				end
			end
			ST_RANK: begin
				if ((j_q == wm1) && i_last) begin
					state_d = ST_PA;
				end
			end
			ST_PA: state_d = ST_PB;
			ST_PB: state_d = ST_PC;
			ST_PC: begin
				if (i_last) begin
					state_d = flush_pend_q ? ST_FA : ST_IDLE;
				end else begin
					state_d = ST_PA;
				end
			end
			ST_FA: state_d = ST_FB;
			ST_FB: begin
				if (s_hit) begin
					state_d = ST_FC;
				end else if (i_last) begin
					state_d    = mode_q ? ST_DA : ST_IDLE;
					flush_done = !mode_q;
				end else begin
					state_d = ST_FA;
				end
			end
			ST_FC: begin
				if (mode_q || out_free) begin
					out_load = !mode_q;
					plain_we = mode_q;
					if (i_last) begin
						state_d    = mode_q ? ST_DA : ST_IDLE;
						flush_done = !mode_q;
					end else begin
						state_d = ST_FA;
					end
				end
			end
			ST_DA: state_d = ST_DB;
			ST_DB: begin
				if (out_free) begin
					out_load = 1'b1;
					if (i_q == fill_m1) begin
						state_d    = ST_IDLE;
						flush_done = 1'b1;
					end else begin
						state_d = ST_DA;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q     <= '0;
			key_high_q    <= '0;
			key_len_q     <= LEN_W'(1);
			order_ready_q <= 1'b0;
			started_q     <= 1'b0;
			mode_q        <= 1'b0;
			end_q         <= 1'b0;
			flush_pend_q  <= 1'b0;
			width_q       <= WID_W'(1);
			fill_q        <= '0;
			cnt_q         <= '0;
			i_q           <= '0;
			j_q           <= '0;
			k_q           <= '0;
			rank_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!started_q) begin
							mode_q    <= action;
							width_q   <= clamp_w;
							started_q <= 1'b1;
						end
						fill_q       <= new_fill;
						end_q        <= message_end;
						flush_pend_q <= flush_now;
						i_q          <= '0;
						j_q          <= '0;
						k_q          <= '0;
						rank_q       <= '0;
						cnt_q        <= '0;
					end
				end
				ST_RANK: begin
					if (j_q == wm1) begin
						j_q    <= '0;
						rank_q <= '0;
						i_q    <= i_last ? '0 : i_q + COL_W'(1);
					end else begin
						j_q    <= j_q + COL_W'(1);
						rank_q <= rank_fin;
					end
				end
				ST_PC: begin
					i_q <= i_last ? '0 : i_q + COL_W'(1);
					if (i_last) begin
						order_ready_q <= 1'b1;
					end
				end
				ST_FB: begin
					if (!s_hit) begin
						i_q <= i_last ? '0 : i_q + COL_W'(1);
					end
				end
				ST_FC: begin
					if (mode_q || out_free) begin
						i_q <= i_last ? '0 : i_q + COL_W'(1);
						k_q <= k_q + COL_W'(1);
					end
				end
				ST_DB: begin
					if (out_free) begin
						i_q <= i_q + COL_W'(1);
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				cnt_q <= cnt_q + WID_W'(1);
			end
			if (flush_done) begin
				fill_q <= '0;
				if (end_q) begin
					started_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_LOW: begin
						key_low_q     <= cfg_data;
						order_ready_q <= 1'b0;
					end
					REG_KEY_HIGH: begin
						key_high_q    <= cfg_data;
						order_ready_q <= 1'b0;
					end
					REG_KEY_LENGTH: begin
						key_len_q     <= cfg_data[LEN_W-1:0];
						order_ready_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_mem[wr_col] <= in_byte;
		end
		if ((state_q == ST_RANK) && (j_q == wm1)) begin
			order_mem[rank_fin] <= i_q;
		end
		if (state_q == ST_PC) begin
			perm_mem[i_q] <= order_rd_q;
		end
		if (plain_we) begin
			plain_mem[perm_rd_q] <= row_rd_q;
		end
		row_rd_q   <= row_mem[row_addr];
		plain_rd_q <= plain_mem[i_q];
		order_rd_q <= order_mem[order_addr];
		perm_rd_q  <= perm_mem[i_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_last_q  <= end_q && (cnt_q == fill_q - WID_W'(1));
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= mode_q ? plain_rd_q : row_rd_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

`ifndef SYNTH
	a_rank_only_when_stale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANK) |-> !order_ready_q)
		else $error("key ranking while order table is current");

	a_emit_within_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (cnt_q < fill_q))
		else $error("more bytes emitted than the row holds");

	a_perm_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FB) |-> ({1'b0, perm_rd_q} < width_q))
		else $error("permuted column beyond row width");

	a_flush_complete: assert property (@(posedge clk) disable iff (!arst_n)
		flush_done |-> ((cnt_q + WID_W'(out_load)) == fill_q) || mode_q)
		else $error("row flush ended with bytes missing");
`endif

endmodule
